// File: design/tpng_pkg.sv
// tpng_pkg: shared types, codes and byte classification for the prefix n-gram tokenizer.
// No dependencies.
package tpng_pkg;

   typedef enum logic [1:0] {
      KIND_TEXT     = 2'd0,
      KIND_STOP_CHR = 2'd1,
      KIND_STOP_LEN = 2'd2,
      KIND_END      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_NGRAM    = 2'd0,
      STAT_OK       = 2'd1,
      STAT_NO_WORDS = 2'd2,
      STAT_NO_NGRAM = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LREAD,
      ST_LCHK,
      ST_CREAD,
      ST_CCHK,
      ST_EMIT,
      ST_STATUS
   } state_type;

   localparam int REG_MIN_LEN = 0;
   localparam int REG_MAX_LEN = 1;

   // punctuation to space, upper case to lower case
   function automatic logic [7:0] norm_char(input logic [7:0] c);
      logic punct;
      punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
              (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
      if (punct) begin
         return 8'h20;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end else begin
         return c;
      end
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'h00;
   endfunction

endpackage

// File: design/tpng_stop_mem.sv
// tpng_stop_mem: stop-word character and length memories, registered reads.
// Depends on nothing; addressed by the tokenizer top level.
module tpng_stop_mem #(
   parameter int SLOT_W = 6,
   parameter int POS_W  = 4
) (
   input  logic                    clock,
   input  logic                    char_we,
   input  logic [SLOT_W+POS_W-1:0] char_waddr,
   input  logic [7:0]              char_wdata,
   input  logic [SLOT_W+POS_W-1:0] char_raddr,
   output logic [7:0]              char_rdata,
   input  logic                    len_we,
   input  logic [SLOT_W-1:0]       len_waddr,
   input  logic [4:0]              len_wdata,
   input  logic [SLOT_W-1:0]       len_raddr,
   output logic [4:0]              len_rdata
);

   logic [7:0] char_mem [2**(SLOT_W+POS_W)];
   logic [4:0] len_mem  [2**SLOT_W];
   logic [7:0] char_q_ff;
   logic [4:0] len_q_ff;

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_waddr] <= char_wdata;
      end
      char_q_ff <= char_mem[char_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_q_ff <= len_mem[len_raddr];
   end

   assign char_rdata = char_q_ff;
   assign len_rdata  = len_q_ff;

endmodule

// File: design/text_prefix_ngram_tokenizer_unit.sv
// text_prefix_ngram_tokenizer_unit: tokenizer top level, control sequencer and output register.
// Depends on tpng_pkg and tpng_stop_mem.
//
//  channel | dir | transfer when            | contents
//  req_    | in  | req_tvalid & req_tready  | tuser kind, tdata char/slot/pos/len
//  rsp_    | out | rsp_tvalid & rsp_tready  | tuser status, tdata index/len/chars, tlast
//  csr_    | in  | csr_wen                  | index 0 min length, 1 max length
//
// A token end scans the stop-word entries until one matches, reading each entry's length
// and then comparing its characters, then emits one result per prefix. After reset a
// clearing pass zeroes the length memory; no request is taken meanwhile. Output stalls
// hold the sequencer in its emit or status step.
module text_prefix_ngram_tokenizer_unit
   import tpng_pkg::*;
#(
   parameter int STOP_ENTRIES    = 64,
   parameter int STOP_WORD_CHARS = 16,
   parameter int MAX_NGRAM       = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_code, slot, position, word_length, pad
   input  logic [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // token_index, ngram_length, ngram_chars, pad
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int SLOT_W = (STOP_ENTRIES > 1) ? $clog2(STOP_ENTRIES) : 1;
   localparam int POS_W  = $clog2(STOP_WORD_CHARS);
   localparam int LEN_W  = $clog2(STOP_WORD_CHARS + 2);
   localparam int CMP_W  = (LEN_W > 5) ? LEN_W + 1 : 6;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   tok_len_ff, tok_len_in;
   logic [7:0]         tok_buf_ff [STOP_WORD_CHARS];
   logic               buf_we;
   logic [POS_W-1:0]   buf_waddr;
   logic [7:0]         buf_wdata;
   logic [15:0]        counter_ff, counter_in;
   logic               kept_ff, kept_in;
   logic               eot_ff, eot_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [3:0]         j_ff, j_in;
   logic [3:0]         hi_ff, hi_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [3:0]         min_ff, max_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_index_ff, rsp_index_in;
   logic [3:0]         rsp_len_ff, rsp_len_in;
   logic [63:0]        rsp_chars_ff, rsp_chars_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_load;

   logic               char_we, len_we;
   logic [SLOT_W+POS_W-1:0] char_waddr;
   logic [SLOT_W-1:0]  len_waddr;
   logic [4:0]         len_wdata;
   logic [7:0]         char_rdata;
   logic [4:0]         len_rdata;

   logic [7:0]         in_char, nchar;
   logic [5:0]         in_slot;
   logic [3:0]         in_pos;
   logic [4:0]         in_wlen;
   kind_type           in_kind;
   logic               out_free;
   logic [3:0]         lo, maxe, tl4, hi;
   logic               slot_ok;

   assign in_char = req_tdata[7:0];
   assign in_slot = req_tdata[13:8];
   assign in_pos  = req_tdata[17:14];
   assign in_wlen = req_tdata[22:18];
   assign in_kind = kind_type'(req_tuser);
   assign nchar   = norm_char(in_char);
   assign slot_ok = 32'(in_slot) < STOP_ENTRIES;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign lo   = (min_ff == 4'd0) ? 4'd1 : min_ff;
   assign maxe = (32'(max_ff) > MAX_NGRAM) ? 4'(MAX_NGRAM) : max_ff;
   assign tl4  = (32'(tok_len_ff) > 8) ? 4'd8 : 4'(tok_len_ff);
   assign hi   = (maxe < tl4) ? maxe : tl4;

   tpng_stop_mem #(
      .SLOT_W (SLOT_W),
      .POS_W  (POS_W)
   ) u_mem (
      .clock      (clock),
      .char_we    (char_we),
      .char_waddr (char_waddr),
      .char_wdata (in_char),
      .char_raddr ({slot_ff, idx_ff}),
      .char_rdata (char_rdata),
      .len_we     (len_we),
      .len_waddr  (len_waddr),
      .len_wdata  (len_wdata),
      .len_raddr  (slot_ff),
      .len_rdata  (len_rdata)
   );

   assign char_waddr = {SLOT_W'(in_slot), POS_W'(in_pos)};

   always_comb begin
      state_in      = state_ff;
      tok_len_in    = tok_len_ff;
      counter_in    = counter_ff;
      kept_in       = kept_ff;
      eot_in        = eot_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      hi_in         = hi_ff;
      clr_in        = clr_ff;
      buf_we        = 1'b0;
      buf_waddr     = tok_len_ff[POS_W-1:0];
      buf_wdata     = nchar;
      char_we       = 1'b0;
      len_we        = 1'b0;
      len_waddr     = SLOT_W'(in_slot);
      len_wdata     = in_wlen;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_NGRAM;
      rsp_index_in  = counter_ff;
      rsp_len_in    = j_ff;
      rsp_last_in   = 1'b0;
      rsp_chars_in  = '0;
      for (int k = 0; k < 8; k++) begin
         if (4'(k) < j_ff) begin
            rsp_chars_in[8*k +: 8] = tok_buf_ff[k];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            len_we    = 1'b1;
            len_waddr = clr_ff;
            len_wdata = 5'd0;
            if (32'(clr_ff) == STOP_ENTRIES - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (in_kind)
                  KIND_TEXT: begin
                     if (is_delim(nchar)) begin
                        if (tok_len_ff != '0) begin
                           eot_in   = 1'b0;
                           slot_in  = '0;
                           state_in = ST_LREAD;
                        end
                     end else begin
                        if (32'(tok_len_ff) < STOP_WORD_CHARS) begin
                           buf_we = 1'b1;
                        end
                        if (32'(tok_len_ff) <= STOP_WORD_CHARS) begin
                           tok_len_in = tok_len_ff + 1'b1;
                        end
                     end
                  end
                  KIND_STOP_CHR: begin
                     char_we = slot_ok && (32'(in_pos) < STOP_WORD_CHARS);
                  end
                  KIND_STOP_LEN: begin
                     len_we = slot_ok;
                  end
                  KIND_END: begin
                     eot_in  = 1'b1;
                     slot_in = '0;
                     if (tok_len_ff != '0) begin
                        state_in = ST_LREAD;
                     end else begin
                        state_in = ST_STATUS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LREAD: begin
            state_in = ST_LCHK;
         end
         ST_LCHK: begin
            idx_in = '0;
            if (len_rdata != 5'd0 && 32'(len_rdata) <= STOP_WORD_CHARS &&
                CMP_W'(len_rdata) == CMP_W'(tok_len_ff)) begin
               state_in = ST_CREAD;
            end else if (32'(slot_ff) == STOP_ENTRIES - 1) begin
               state_in = ST_EMIT;
               kept_in  = 1'b1;
               j_in     = lo;
               hi_in    = hi;
               if (hi < lo) begin
                  tok_len_in = '0;
                  state_in   = eot_ff ? ST_STATUS : ST_IDLE;
               end
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_LREAD;
            end
         end
         ST_CREAD: begin
            state_in = ST_CCHK;
         end
         ST_CCHK: begin
            if (char_rdata == tok_buf_ff[idx_ff]) begin
               if (CMP_W'(idx_ff) + 1'b1 == CMP_W'(len_rdata)) begin
                  tok_len_in = '0;
                  state_in   = eot_ff ? ST_STATUS : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_CREAD;
               end
            end else if (32'(slot_ff) == STOP_ENTRIES - 1) begin
               state_in = ST_EMIT;
               kept_in  = 1'b1;
               j_in     = lo;
               hi_in    = hi;
               if (hi < lo) begin
                  tok_len_in = '0;
                  state_in   = eot_ff ? ST_STATUS : ST_IDLE;
               end
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_LREAD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = (j_ff == hi_ff) && !eot_ff;
               if (j_ff == hi_ff) begin
                  if (counter_ff != 16'hFFFF) begin
                     counter_in = counter_ff + 1'b1;
                  end
                  tok_len_in = '0;
                  state_in   = eot_ff ? ST_STATUS : ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_index_in  = '0;
               rsp_len_in    = '0;
               rsp_chars_in  = '0;
               rsp_last_in   = 1'b1;
               if (!kept_ff) begin
                  rsp_status_in = STAT_NO_WORDS;
               end else if (counter_ff == 16'd0) begin
                  rsp_status_in = STAT_NO_NGRAM;
               end else begin
                  rsp_status_in = STAT_OK;
               end
               counter_in = '0;
               kept_in    = 1'b0;
               eot_in     = 1'b0;
               tok_len_in = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         tok_len_ff   <= '0;
         counter_ff   <= '0;
         kept_ff      <= 1'b0;
         eot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= 4'd1;
         max_ff       <= 4'd8;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tok_len_ff   <= tok_len_in;
         counter_ff   <= counter_in;
         kept_ff      <= kept_in;
         eot_ff       <= eot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && csr_index == 1'(REG_MIN_LEN)) begin
            min_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == 1'(REG_MAX_LEN)) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      hi_ff   <= hi_in;
      if (buf_we) begin
         tok_buf_ff[buf_waddr] <= buf_wdata;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_chars_ff  <= rsp_chars_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_chars_ff, rsp_len_ff, rsp_index_ff};

endmodule

// File: design/tpng_checker.sv
// tpng_checker: port-level assertions on the tokenizer result channel, bound to the top level.
// Depends on tpng_pkg.
module tpng_checker
   import tpng_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_NGRAM |-> rsp_tdata == '0 && rsp_tlast)
      else $error("status result carries data or lacks last");

   a_ngram_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_NGRAM |-> rsp_tdata[19:16] != 4'd0 &&
      rsp_tdata[19:16] <= 4'd8)
      else $error("prefix length out of range");

   a_chars_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_NGRAM && rsp_tdata[19:16] == 4'd1 |->
      rsp_tdata[83:28] == '0)
      else $error("unused prefix bytes not zero");

endmodule

bind text_prefix_ngram_tokenizer_unit tpng_checker u_tpng_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: test/tb_text_prefix_ngram_tokenizer_unit.sv
// Self-checking testbench for text_prefix_ngram_tokenizer_unit: drives text and stop-word
// transfers, predicts the prefix and status results in a scoreboard class and checks them.
// Depends on tpng_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module tb_text_prefix_ngram_tokenizer_unit;
   import tpng_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE_CYCS = 2500;

   typedef struct {
      status_type  st;
      logic [15:0] idx;
      logic [3:0]  len;
      logic [63:0] chars;
      logic        last;
   } ngram_result_type;

   class tokenizer_scoreboard;
      logic [7:0]       tok_buf[16];
      int               tok_len, tok_count;
      bit               any_tok, kept_tok;
      logic [7:0]       stop_chr[64][16];
      int               stop_len[64];
      int               min_len = 1, max_len = 8;
      ngram_result_type pending_q[$];
      int               n_err;

      function void set_reg(int idx, int val);
         if (idx == REG_MIN_LEN) min_len = val;
         else max_len = val;
      endfunction

      function bit stop_hit();
         bit ok;
         if (tok_len > 16) return 0;
         for (int s = 0; s < 64; s++) begin
            if (stop_len[s] == 0 || stop_len[s] > 16 || stop_len[s] != tok_len) continue;
            ok = 1;
            for (int i = 0; i < stop_len[s]; i++)
               if (stop_chr[s][i] != tok_buf[i]) ok = 0;
            if (ok) return 1;
         end
         return 0;
      endfunction

      function int end_token();
         int lo, hi, n;
         ngram_result_type r;
         n = 0;
         if (tok_len == 0) return 0;
         any_tok = 1;
         if (stop_hit()) begin
            tok_len = 0;
            return 0;
         end
         kept_tok = 1;
         lo = (min_len == 0) ? 1 : min_len;
         hi = (max_len > 8) ? 8 : max_len;
         if (hi > tok_len) hi = tok_len;
         if (tok_len >= lo) begin
            for (int j = lo; j <= hi; j++) begin
               r.st = STAT_NGRAM;
               r.idx = tok_count[15:0];
               r.len = j[3:0];
               r.chars = '0;
               for (int i = 0; i < j; i++) r.chars[8*i +: 8] = tok_buf[i];
               r.last = 0;
               pending_q = {pending_q, r};
               n++;
            end
            if (n > 0 && tok_count < 16'hFFFF) tok_count++;
         end
         tok_len = 0;
         return n;
      endfunction

      function void note(kind_type k, logic [7:0] c, logic [5:0] s, logic [3:0] p,
                         logic [4:0] l);
         bit punct;
         int n;
         ngram_result_type r;
         case (k)
            KIND_STOP_CHR: stop_chr[s][p] = c;
            KIND_STOP_LEN: stop_len[s] = l;
            KIND_TEXT: begin
               punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                       (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
               if (punct) c = 8'h20;
               if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
               if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'h00) begin
                  n = end_token();
                  if (n > 0) pending_q[pending_q.size()-1].last = 1;
               end else begin
                  if (tok_len < 16) tok_buf[tok_len] = c;
                  if (tok_len <= 16) tok_len++;
               end
            end
            default: begin
               void'(end_token());
               r.st = !kept_tok ? STAT_NO_WORDS : (tok_count == 0) ? STAT_NO_NGRAM : STAT_OK;
               r.idx = '0;
               r.len = '0;
               r.chars = '0;
               r.last = 1;
               pending_q = {pending_q, r};
               tok_len = 0;
               tok_count = 0;
               any_tok = 0;
               kept_tok = 0;
            end
         endcase
      endfunction

      function void check(logic [1:0] st, logic [15:0] idx, logic [3:0] len,
                          logic [63:0] chars, logic last);
         ngram_result_type e;
         if (pending_q.size() == 0) begin
            $error("unexpected result status=%0d idx=%0d len=%0d", st, idx, len);
            n_err++;
            return;
         end
         e = pending_q.pop_front();
         if (st !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, st); n_err++;
         end
         if (idx !== e.idx) begin
            $error("token_index: expected %0d, got %0d", e.idx, idx); n_err++;
         end
         if (len !== e.len) begin
            $error("ngram_length: expected %0d, got %0d", e.len, len); n_err++;
         end
         if (chars !== e.chars) begin
            $error("ngram_chars: expected %h, got %h", e.chars, chars); n_err++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last); n_err++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen = 0;
   logic        csr_index = 0;
   logic [3:0]  csr_wdata = '0;

   tokenizer_scoreboard sb = new();
   bit quiet = 0;
   bit hold_req = 0, hold_ack = 0;
   int hold_cnt = 0, stall_cnt = 0, idle_cycles = 0;
   int n_items = 0;

   text_prefix_ngram_tokenizer_unit uut (.*);

   always #6 clock = ~clock;

   // result side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cnt > 0) begin
         rsp_tready <= 0;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_cnt <= 400;
         rsp_tready <= 0;
      end else if (quiet) begin
         rsp_tready <= 1;
      end else if (stall_cnt > 0) begin
         rsp_tready <= 0;
         stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         stall_cnt <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check(rsp_tuser, rsp_tdata[15:0], rsp_tdata[19:16], rsp_tdata[83:20], rsp_tlast);
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send(kind_type k, logic [7:0] c, logic [5:0] s, logic [3:0] p,
                       logic [4:0] l);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= k;
      req_tdata <= {1'b0, l, p, s, c};
      do @(posedge clock); while (!req_tready);
      sb.note(k, c, s, p, l);
      n_items++;
   endtask

   task automatic send_char(logic [7:0] c);
      send(KIND_TEXT, c, 6'($urandom), 4'($urandom), 5'($urandom));
   endtask

   task automatic send_text(string txt);
      for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
   endtask

   task automatic send_end();
      send(KIND_END, 8'($urandom), 6'($urandom), 4'($urandom), 5'($urandom));
   endtask

   // characters first so a live entry never holds unwritten characters
   task automatic add_stop(logic [5:0] s, string w);
      for (int i = 0; i < w.len(); i++) send(KIND_STOP_CHR, w[i], s, 4'(i), 5'($urandom));
      send(KIND_STOP_LEN, 8'($urandom), s, 4'($urandom), 5'(w.len()));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCS) @(posedge clock);
   endtask

   task automatic write_reg(int idx, int val);
      csr_wen <= 1;
      csr_index <= idx[0];
      csr_wdata <= val[3:0];
      @(posedge clock);
      csr_wen <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic string rand_word(int n);
      string w;
      w = "";
      for (int i = 0; i < n; i++) w = {w, string'(8'(8'h61 + $urandom_range(0, 3)))};
      return w;
   endfunction

   task automatic random_items(int count);
      int stop_n;
      int n;
      logic [7:0] c;
      stop_n = n_items + count;
      while (n_items < stop_n) begin
         case ($urandom_range(0, 19))
            0: send_end();
            1: add_stop(6'($urandom), rand_word($urandom_range(1, 4)));
            2: send(KIND_STOP_LEN, 8'($urandom), 6'($urandom), 4'($urandom), 5'd0);
            3: send(KIND_STOP_CHR, 8'($urandom), 6'($urandom), 4'($urandom), 5'($urandom));
            4: send_char(8'($urandom));
            default: begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
               for (int i = 0; i < n; i++) begin
                  c = 8'(8'h61 + $urandom_range(0, 3));
                  case ($urandom_range(0, 9))
                     0: c = c - 8'h20;
                     1: c = 8'($urandom_range(8'h80, 8'hFF));
                     2: c = 8'($urandom_range(8'h01, 8'h08));
                     default: ;
                  endcase
                  send_char(c);
               end
               case ($urandom_range(0, 4))
                  0: send_char(8'h00);
                  1: send_char(8'($urandom_range(8'h09, 8'h0D)));
                  2: send_char(8'h2C);
                  default: send_char(8'h20);
               endcase
            end
         endcase
      end
      send_end();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: stop words, case folding, punctuation, delimiters, long token
      add_stop(6'd0, "the");
      add_stop(6'd5, "a");
      send(KIND_STOP_LEN, 8'hFF, 6'd63, 4'hF, 5'd0);
      send_text("The, A x1!");
      send_char(8'h80);
      send_char(8'h51);
      send_char(8'h09);
      send_end();
      send_text("the a");
      send_end();
      send_end();
      for (int i = 0; i < 20; i++) send_char(8'h7A);
      send_char(8'h00);
      send_char(8'h7F);
      send_end();

      // long result-side hold-off while the sender keeps offering
      hold_req <= 1;
      random_items(15);
      drain();

      write_reg(REG_MIN_LEN, 3);
      write_reg(REG_MAX_LEN, 5);
      random_items(12);
      drain();
      write_reg(REG_MIN_LEN, 0);
      write_reg(REG_MAX_LEN, 15);
      random_items(12);
      drain();
      write_reg(REG_MIN_LEN, 6);
      write_reg(REG_MAX_LEN, 2);
      send_text("abcdefg ab");
      send_end();
      random_items(6);
      drain();
      write_reg(REG_MIN_LEN, 8);
      write_reg(REG_MAX_LEN, 8);
      random_items(8);
      drain();
      write_reg(REG_MIN_LEN, 1);
      write_reg(REG_MAX_LEN, 8);
      quiet = 1;
      random_items(12);

      drain();
      if (sb.n_err == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: text_prefix_ngram_tokenizer_unit.f
design/tpng_pkg.sv
design/tpng_stop_mem.sv
design/text_prefix_ngram_tokenizer_unit.sv
design/tpng_checker.sv
test/tb_text_prefix_ngram_tokenizer_unit.sv
